// File: src/ggh_pkg.sv
// Shared types, widths and constants of the go-to-goal heading controller.
// Used by every module under src; depends on nothing else.
package ggh_pkg;

   // Datapath widths of the vectoring rotator.
   localparam int XW       = 36;   // x and y, Q12.12 with 8 guard bits, plus growth
   localparam int ZW       = 28;   // angle accumulator, Q24 radians
   localparam int ATAN_LEN = 24;
   localparam int CORDIC_ITERATIONS_DEFAULT = 16;

   localparam logic signed [ZW-1:0] PI_Q24     = 28'sd52707179;
   localparam logic signed [17:0]   PI_Q13     = 18'sd25736;
   localparam logic signed [17:0]   TWO_PI_Q13 = 18'sd51472;
   localparam logic        [29:0]   KGAIN_Q30  = 30'd652032874;
   localparam logic        [24:0]   DIST_MAX   = 25'h1FFFFFF;

   // Word index of each control register (byte address bits [4:2]).
   localparam logic [2:0] CSR_GOAL_X    = 3'd0;
   localparam logic [2:0] CSR_GOAL_Y    = 3'd1;
   localparam logic [2:0] CSR_TOLERANCE = 3'd2;
   localparam logic [2:0] CSR_GAIN      = 3'd3;
   localparam logic [2:0] CSR_MIN_RATE  = 3'd4;
   localparam logic [2:0] CSR_MAX_RATE  = 3'd5;

   // Vector handed from one rotator stage to the next.
   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 zero;      // goal coincides with pose
      logic signed [15:0]   heading;
   } cordic_vec_type;

   // Control register values used by the output stages.
   typedef struct packed {
      logic [22:0] tolerance;
      logic [15:0] gain;
      logic [14:0] min_rate;
      logic [14:0] max_rate;
   } turn_cfg_type;

   // Arctangent of 2^-i in Q24 radians.
   function automatic logic signed [ZW-1:0] atan_q24(input int idx);
      logic signed [ZW-1:0] val;
      begin
         case (idx)
            0:       val = 28'sd13176795;
            1:       val = 28'sd7778716;
            2:       val = 28'sd4110060;
            3:       val = 28'sd2086331;
            4:       val = 28'sd1047214;
            5:       val = 28'sd524117;
            6:       val = 28'sd262123;
            7:       val = 28'sd131069;
            8:       val = 28'sd65536;
            9:       val = 28'sd32768;
            10:      val = 28'sd16384;
            11:      val = 28'sd8192;
            12:      val = 28'sd4096;
            13:      val = 28'sd2048;
            14:      val = 28'sd1024;
            15:      val = 28'sd512;
            16:      val = 28'sd256;
            17:      val = 28'sd128;
            18:      val = 28'sd64;
            19:      val = 28'sd32;
            20:      val = 28'sd16;
            21:      val = 28'sd8;
            22:      val = 28'sd4;
            23:      val = 28'sd2;
            default: val = '0;
         endcase
         return val;
      end
   endfunction

endpackage

// File: src/ggh_prep_cell.sv
// Front cell of the rotator chain: goal offset and pre-rotation into the right half plane.
// Depends on ggh_pkg.
module ggh_prep_cell
   import ggh_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_stall,
   input  logic signed [23:0] pose_x,
   input  logic signed [23:0] pose_y,
   input  logic signed [15:0] pose_heading,
   input  logic signed [23:0] goal_x,
   input  logic signed [23:0] goal_y,
   output logic               out_valid,
   input  logic               out_stall,
   output cordic_vec_type     out_vec
);

   logic                 en;
   logic                 valid_ff, valid_in;
   cordic_vec_type       vec_ff, vec_in, vec_calc;
   logic signed [24:0]   dx, dy;
   logic signed [XW-1:0] x0, y0;

   assign en       = !valid_ff || !out_stall;
   assign in_stall = !en;

   always_comb begin
      dx = {goal_x[23], goal_x} - {pose_x[23], pose_x};
      dy = {goal_y[23], goal_y} - {pose_y[23], pose_y};
      x0 = {{(XW-33){dx[24]}}, dx, 8'b0};
      y0 = {{(XW-33){dy[24]}}, dy, 8'b0};
      vec_calc.zero    = (dx == '0) && (dy == '0);
      vec_calc.heading = pose_heading;
      if (dx[24]) begin
         // Left half plane: turn the vector by pi and start the angle there.
         vec_calc.x = -x0;
         vec_calc.y = -y0;
         vec_calc.z = dy[24] ? -PI_Q24 : PI_Q24;
      end else begin
         vec_calc.x = x0;
         vec_calc.y = y0;
         vec_calc.z = '0;
      end
      valid_in = en ? in_valid : valid_ff;
      vec_in   = en ? vec_calc : vec_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      vec_ff <= vec_in;
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;

endmodule

// File: src/ggh_cordic_cell.sv
// One micro-rotation cell of the vectoring chain, shift amount fixed per cell.
// Depends on ggh_pkg.
module ggh_cordic_cell
   import ggh_pkg::*;
#(
   parameter int SHIFT = 0
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_stall,
   input  cordic_vec_type in_vec,
   output logic           out_valid,
   input  logic           out_stall,
   output cordic_vec_type out_vec
);

   localparam logic signed [ZW-1:0] ANGLE = atan_q24(SHIFT);

   logic                 en;
   logic                 valid_ff, valid_in;
   cordic_vec_type       vec_ff, vec_in, vec_calc;
   logic signed [XW-1:0] x_s, y_s, xs, ys;
   logic signed [ZW-1:0] z_s;

   assign en       = !valid_ff || !out_stall;
   assign in_stall = !en;

   always_comb begin
      x_s = in_vec.x;
      y_s = in_vec.y;
      z_s = in_vec.z;
      xs  = x_s >>> SHIFT;
      ys  = y_s >>> SHIFT;
      vec_calc         = in_vec;
      if (!y_s[XW-1]) begin
         vec_calc.x = x_s + ys;
         vec_calc.y = y_s - xs;
         vec_calc.z = z_s + ANGLE;
      end else begin
         vec_calc.x = x_s - ys;
         vec_calc.y = y_s + xs;
         vec_calc.z = z_s - ANGLE;
      end
      valid_in = en ? in_valid : valid_ff;
      vec_in   = en ? vec_calc : vec_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      vec_ff <= vec_in;
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;

endmodule

// File: src/ggh_post.sv
// Output pipe: distance scaling, bearing wrap, proportional turn command and clamp.
// Depends on ggh_pkg.
module ggh_post
   import ggh_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_stall,
   input  cordic_vec_type     in_vec,
   input  turn_cfg_type       cfg,
   output logic               out_valid,
   input  logic               out_stall,
   output logic signed [15:0] turn_command,
   output logic        [24:0] distance_error,
   output logic signed [15:0] heading_error,
   output logic               arrived
);

   logic [3:0] valid_ff, valid_in, en;

   // Stage 1: partial products of the gain scaling, raw heading error.
   logic [46:0]        pp_lo_ff, pp_lo_in;
   logic [47:0]        pp_hi_ff, pp_hi_in;
   logic signed [17:0] err_raw_ff, err_raw_in;
   // Stage 2: rounded distance, wrapped error and its magnitude.
   logic [24:0]        dist2_ff, dist2_in;
   logic signed [15:0] err2_ff, err2_in;
   logic [16:0]        abs2_ff, abs2_in;
   // Stage 3: turn magnitude, sign and arrival.
   logic [19:0]        mag3_ff, mag3_in;
   logic               neg3_ff, neg3_in;
   logic               arr3_ff, arr3_in;
   logic [24:0]        dist3_ff, dist3_in;
   logic signed [15:0] err3_ff, err3_in;
   // Stage 4: output register.
   logic signed [15:0] cmd4_ff, cmd4_in;
   logic [24:0]        dist4_ff, dist4_in;
   logic signed [15:0] err4_ff, err4_in;
   logic               arr4_ff, arr4_in;

   logic [34:0]          x_cl;
   logic signed [ZW-1:0] z_use, z_rnd;
   logic signed [16:0]   bearing;
   logic [65:0]          dsum;
   logic [27:0]          dfull;
   logic signed [17:0]   err_w;
   logic signed [16:0]   e17;
   logic [33:0]          msum;
   logic [14:0]          mag_cl;

   always_comb begin
      en[3] = !valid_ff[3] || !out_stall;
      en[2] = !valid_ff[2] || en[3];
      en[1] = !valid_ff[1] || en[2];
      en[0] = !valid_ff[0] || en[1];
      valid_in[0] = en[0] ? in_valid    : valid_ff[0];
      valid_in[1] = en[1] ? valid_ff[0] : valid_ff[1];
      valid_in[2] = en[2] ? valid_ff[1] : valid_ff[2];
      valid_in[3] = en[3] ? valid_ff[2] : valid_ff[3];
   end

   assign in_stall = !en[0];

   // Stage 1.
   always_comb begin
      x_cl    = in_vec.x[XW-1] ? '0 : in_vec.x[34:0];
      z_use   = in_vec.zero ? '0 : in_vec.z;
      z_rnd   = z_use + 28'sd1024;
      bearing = z_rnd[ZW-1:11];
      pp_lo_in   = en[0] ? (47'(x_cl[16:0]) * 47'(KGAIN_Q30)) : pp_lo_ff;
      pp_hi_in   = en[0] ? (48'(x_cl[34:17]) * 48'(KGAIN_Q30)) : pp_hi_ff;
      err_raw_in = en[0] ? ({bearing[16], bearing} - 18'(in_vec.heading)) : err_raw_ff;
   end

   // Stage 2.
   always_comb begin
      dsum  = 66'(pp_lo_ff) + (66'(pp_hi_ff) << 17) + (66'd1 << 37);
      dfull = dsum[65:38];
      if (err_raw_ff > PI_Q13) begin
         err_w = err_raw_ff - TWO_PI_Q13;
      end else if (err_raw_ff < -PI_Q13) begin
         err_w = err_raw_ff + TWO_PI_Q13;
      end else begin
         err_w = err_raw_ff;
      end
      e17 = {err_w[15], err_w[15:0]};
      dist2_in = en[1] ? ((dfull > 28'(DIST_MAX)) ? DIST_MAX : dfull[24:0]) : dist2_ff;
      err2_in  = en[1] ? err_w[15:0] : err2_ff;
      abs2_in  = en[1] ? (e17[16] ? 17'(-e17) : 17'(e17)) : abs2_ff;
   end

   // Stage 3.
   always_comb begin
      msum     = (34'(cfg.gain) * 34'(abs2_ff)) + 34'd8192;
      mag3_in  = en[2] ? msum[33:14] : mag3_ff;
      neg3_in  = en[2] ? (err2_ff[15] && (cfg.gain != '0)) : neg3_ff;
      arr3_in  = en[2] ? (dist2_ff <= {2'b00, cfg.tolerance}) : arr3_ff;
      dist3_in = en[2] ? dist2_ff : dist3_ff;
      err3_in  = en[2] ? err2_ff : err3_ff;
   end

   // Stage 4: the below-min test wins over the above-max test.
   always_comb begin
      if (mag3_ff < 20'(cfg.min_rate)) begin
         mag_cl = cfg.min_rate;
      end else if (mag3_ff > 20'(cfg.max_rate)) begin
         mag_cl = cfg.max_rate;
      end else begin
         mag_cl = mag3_ff[14:0];
      end
      cmd4_in  = en[3] ? (neg3_ff ? -$signed({1'b0, mag_cl}) : $signed({1'b0, mag_cl}))
                       : cmd4_ff;
      dist4_in = en[3] ? dist3_ff : dist4_ff;
      err4_in  = en[3] ? err3_ff : err4_ff;
      arr4_in  = en[3] ? arr3_ff : arr4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      pp_lo_ff   <= pp_lo_in;
      pp_hi_ff   <= pp_hi_in;
      err_raw_ff <= err_raw_in;
      dist2_ff   <= dist2_in;
      err2_ff    <= err2_in;
      abs2_ff    <= abs2_in;
      mag3_ff    <= mag3_in;
      neg3_ff    <= neg3_in;
      arr3_ff    <= arr3_in;
      dist3_ff   <= dist3_in;
      err3_ff    <= err3_in;
      cmd4_ff    <= cmd4_in;
      dist4_ff   <= dist4_in;
      err4_ff    <= err4_in;
      arr4_ff    <= arr4_in;
   end

   assign out_valid      = valid_ff[3];
   assign turn_command   = cmd4_ff;
   assign distance_error = dist4_ff;
   assign heading_error  = err4_ff;
   assign arrived        = arr4_ff;

endmodule

// File: src/go_to_goal_heading_controller.sv
// Top level of the go-to-goal heading controller: control registers and the cell chain.
// Depends on ggh_pkg, ggh_prep_cell, ggh_cordic_cell and ggh_post.
//
// Usage. Each beat on the req channel carries one odometry pose (x, y in Q12.12
// metres, heading in Q13 radians). For every request beat exactly one beat leaves
// on the rsp channel, in order: the distance to the goal, the heading error wrapped
// into plus or minus pi, a turn-rate command clamped into the min/max band, and an
// arrived flag. Goal, tolerance, gain and rate band live in six 32-bit registers on
// the APB-style port at byte addresses 0, 4, 8, 12, 16 and 20; they should only be
// written while no beat is in flight.
// From request to response a beat passes one front cell, one cell per micro-rotation
// (their count capped at the 24 entries of the arctangent table) and four output
// stages (scaling multiply, rounding and wrap, gain multiply, clamp into the output
// register). Throughput is one beat per cycle while rsp_stall is low, set by the
// micro-rotation chain where each cell holds one vector.
// Every stage has its own valid bit, so bubbles close up: while rsp_stall holds a
// finished beat in the output register, earlier stages keep filling, and req_stall
// rises only once the whole chain is full. A held response does not change.
// Synchronous reset empties the chain and loads the registers with their defaults
// (goal at the origin, tolerance 102, gain 0.5, band 0.09 to 1.0 rad/s).
module go_to_goal_heading_controller
   import ggh_pkg::*;
#(
   parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEFAULT
)
(
   input  logic               clock,
   input  logic               reset,
   // Pose requests.
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [23:0] req_pose_x,
   input  logic signed [23:0] req_pose_y,
   input  logic signed [15:0] req_pose_heading,
   // Controller responses.
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_turn_command,
   output logic        [24:0] rsp_distance_error,
   output logic signed [15:0] rsp_heading_error,
   output logic               rsp_arrived,
   // Register port.
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic        [4:0]  paddr,
   input  logic        [31:0] pwdata,
   output logic        [31:0] prdata,
   output logic               pready
);

   // Micro-rotations beyond the arctangent table are not built.
   localparam int ROT_CELLS = (CORDIC_ITERATIONS < ATAN_LEN) ? CORDIC_ITERATIONS : ATAN_LEN;

   // ------------------------------------------------------------------
   // Control registers.
   // ------------------------------------------------------------------
   logic signed [23:0] goal_x_ff, goal_x_in;
   logic signed [23:0] goal_y_ff, goal_y_in;
   logic        [22:0] tol_ff, tol_in;
   logic        [15:0] gain_ff, gain_in;
   logic        [14:0] min_ff, min_in;
   logic        [14:0] max_ff, max_in;
   logic               csr_write;
   logic        [2:0]  csr_index;

   assign pready    = 1'b1;
   assign csr_index = paddr[4:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      goal_x_in = goal_x_ff;
      goal_y_in = goal_y_ff;
      tol_in    = tol_ff;
      gain_in   = gain_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_GOAL_X:    goal_x_in = pwdata[23:0];
            CSR_GOAL_Y:    goal_y_in = pwdata[23:0];
            CSR_TOLERANCE: tol_in    = pwdata[22:0];
            CSR_GAIN:      gain_in   = pwdata[15:0];
            CSR_MIN_RATE:  min_in    = pwdata[14:0];
            CSR_MAX_RATE:  max_in    = pwdata[14:0];
            default: ;
         endcase
      end
   end

   // Reads return the register value; the goal coordinates come back sign extended.
   always_comb begin
      unique case (csr_index)
         CSR_GOAL_X:    prdata = {{8{goal_x_ff[23]}}, goal_x_ff};
         CSR_GOAL_Y:    prdata = {{8{goal_y_ff[23]}}, goal_y_ff};
         CSR_TOLERANCE: prdata = {9'b0, tol_ff};
         CSR_GAIN:      prdata = {16'b0, gain_ff};
         CSR_MIN_RATE:  prdata = {17'b0, min_ff};
         CSR_MAX_RATE:  prdata = {17'b0, max_ff};
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff <= '0;
         goal_y_ff <= '0;
         tol_ff    <= 23'd102;
         gain_ff   <= 16'd8192;
         min_ff    <= 15'd737;
         max_ff    <= 15'd8192;
      end else begin
         goal_x_ff <= goal_x_in;
         goal_y_ff <= goal_y_in;
         tol_ff    <= tol_in;
         gain_ff   <= gain_in;
         min_ff    <= min_in;
         max_ff    <= max_in;
      end
   end

   // ------------------------------------------------------------------
   // Cell chain. Entry k of the arrays is the link into micro-rotation k;
   // the last entry feeds the output stages.
   // ------------------------------------------------------------------
   cordic_vec_type chain_vec   [ROT_CELLS+1];
   logic           chain_valid [ROT_CELLS+1];
   logic           chain_stall [ROT_CELLS+1];
   turn_cfg_type   turn_cfg;

   ggh_prep_cell u_prep (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_stall     (req_stall),
      .pose_x       (req_pose_x),
      .pose_y       (req_pose_y),
      .pose_heading (req_pose_heading),
      .goal_x       (goal_x_ff),
      .goal_y       (goal_y_ff),
      .out_valid    (chain_valid[0]),
      .out_stall    (chain_stall[0]),
      .out_vec      (chain_vec[0])
   );

   for (genvar g = 0; g < ROT_CELLS; g++) begin : g_rot
      ggh_cordic_cell #(
         .SHIFT (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[g]),
         .in_stall  (chain_stall[g]),
         .in_vec    (chain_vec[g]),
         .out_valid (chain_valid[g+1]),
         .out_stall (chain_stall[g+1]),
         .out_vec   (chain_vec[g+1])
      );
   end

   assign turn_cfg.tolerance = tol_ff;
   assign turn_cfg.gain      = gain_ff;
   assign turn_cfg.min_rate  = min_ff;
   assign turn_cfg.max_rate  = max_ff;

   ggh_post u_post (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (chain_valid[ROT_CELLS]),
      .in_stall       (chain_stall[ROT_CELLS]),
      .in_vec         (chain_vec[ROT_CELLS]),
      .cfg            (turn_cfg),
      .out_valid      (rsp_valid),
      .out_stall      (rsp_stall),
      .turn_command   (rsp_turn_command),
      .distance_error (rsp_distance_error),
      .heading_error  (rsp_heading_error),
      .arrived        (rsp_arrived)
   );

   // ------------------------------------------------------------------
   // Checks.
   // ------------------------------------------------------------------
   logic [15:0] cmd_abs;
   assign cmd_abs = rsp_turn_command[15] ? 16'(-rsp_turn_command) : 16'(rsp_turn_command);

   // The chain is empty in the first cycle after reset is released.
   a_empty_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("response valid right after reset");

   // The arrived flag agrees with the delivered distance and the tolerance.
   a_arrived_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_arrived == (rsp_distance_error <= {2'b00, tol_ff})))
      else $error("arrived flag disagrees with distance");

   // The command magnitude is the minimum, the maximum or lies inside the band.
   a_turn_band: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((cmd_abs == {1'b0, min_ff}) || (cmd_abs == {1'b0, max_ff}) ||
                     ((cmd_abs >= {1'b0, min_ff}) && (cmd_abs <= {1'b0, max_ff}))))
      else $error("turn command outside the rate band");

   // A non-negative heading error never gives a negative turn.
   a_turn_sign: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_heading_error[15]) |-> !rsp_turn_command[15])
      else $error("turn sign disagrees with heading error");

endmodule
